### hw/rtl/mi4_pkg.sv
// mi4_pkg: shared types, constants and the term sequencing function
// for the 4x4 matrix inverse unit. No dependencies.
`timescale 1ns / 1ps

package mi4_pkg;

  localparam int AW   = 168;  // accumulator width
  localparam int DETW = 136;  // determinant width
  localparam int YW   = 128;  // operand buffer width (four limbs)

  localparam logic [4:0] GRP_COF = 5'd12;
  localparam logic [4:0] GRP_DET = 5'd28;

  localparam logic [1:0] YS_ELEM = 2'd0;
  localparam logic [1:0] YS_S2   = 2'd1;
  localparam logic [1:0] YS_COF  = 2'd2;

  typedef struct packed {
    logic [3:0] x_idx;
    logic [1:0] ysrc;
    logic [3:0] y_idx;
    logic       neg;
    logic       last;
    logic [1:0] nlimb_m1;
  } term_t;

  function automatic logic [2:0] pair_idx(logic [1:0] p, logic [1:0] q);
    logic [2:0] r;
    case ({p, q})
      4'h1:    r = 3'd0;
      4'h2:    r = 3'd1;
      4'h3:    r = 3'd2;
      4'h6:    r = 3'd3;
      4'h7:    r = 3'd4;
      default: r = 3'd5;
    endcase
    return r;
  endfunction

  function automatic term_t term_info(logic [4:0] grp, logic [1:0] trm);
    term_t      t;
    logic       half;
    logic [2:0] g6;
    logic [1:0] p, q, r1, r2, r, c, ct, tu, tv, cu, cv, rx;
    logic [3:0] ci;
    logic [2:0] base;
    t = '0;
    if (grp < GRP_COF) begin
      half = (grp >= 5'd6);
      g6   = half ? 3'(grp - 5'd6) : grp[2:0];
      case (g6)
        3'd0:    begin p = 2'd0; q = 2'd1; end
        3'd1:    begin p = 2'd0; q = 2'd2; end
        3'd2:    begin p = 2'd0; q = 2'd3; end
        3'd3:    begin p = 2'd1; q = 2'd2; end
        3'd4:    begin p = 2'd1; q = 2'd3; end
        default: begin p = 2'd2; q = 2'd3; end
      endcase
      r1 = half ? 2'd0 : 2'd2;
      r2 = half ? 2'd1 : 2'd3;
      if (trm == 2'd0) begin
        t.x_idx = {r1, p};
        t.y_idx = {r2, q};
        t.neg   = 1'b0;
      end else begin
        t.x_idx = {r1, q};
        t.y_idx = {r2, p};
        t.neg   = 1'b1;
      end
      t.ysrc     = YS_ELEM;
      t.last     = (trm == 2'd1);
      t.nlimb_m1 = 2'd0;
    end else if (grp < GRP_DET) begin
      ci = 4'(grp - GRP_COF);
      r  = ci[3:2];
      c  = ci[1:0];
      ct = (trm < c) ? trm : 2'(trm + 2'd1);
      tu = (trm == 2'd0) ? 2'd1 : 2'd0;
      tv = (trm == 2'd2) ? 2'd1 : 2'd2;
      cu = (tu < c) ? tu : 2'(tu + 2'd1);
      cv = (tv < c) ? tv : 2'(tv + 2'd1);
      case (r)
        2'd0:    rx = 2'd1;
        2'd1:    rx = 2'd0;
        2'd2:    rx = 2'd3;
        default: rx = 2'd2;
      endcase
      base       = r[1] ? 3'd6 : 3'd0;
      t.x_idx    = {rx, ct};
      t.y_idx    = {1'b0, base} + {1'b0, pair_idx(cu, cv)};
      t.neg      = (trm == 2'd1) ^ r[0] ^ c[0];
      t.ysrc     = YS_S2;
      t.last     = (trm == 2'd2);
      t.nlimb_m1 = 2'd2;
    end else begin
      t.x_idx    = {2'd0, trm};
      t.y_idx    = {2'd0, trm};
      t.neg      = 1'b0;
      t.ysrc     = YS_COF;
      t.last     = (trm == 2'd3);
      t.nlimb_m1 = 2'd3;
    end
    return t;
  endfunction

endpackage

### hw/rtl/matrix4_inverse_unit.sv
// matrix4_inverse_unit: 4x4 fixed-point matrix inverse by cofactors and
// adjugate on one shared 33x33 multiplier and a restoring divider.
// Depends on mi4_pkg.
//
// Usage: feed 16 signed elements, row-major, on in_element_in with start
// while busy is low; each accepted word stores one element. The sixteenth
// word raises busy. The unit then forms twelve 2x2 minors, sixteen
// cofactors and the determinant, one 33x33 limb product per cycle in the
// multiply state, and divides each adjugate entry by the determinant one
// quotient bit a cycle. Results come out row-major, one word per
// out_valid pulse, with out_last_element on the sixteenth; out_singular
// flags a zero determinant and then all elements are zero. The receiver
// cannot stall. Each element passes setup, range check, divide steps and
// emit; the divide steps are skipped when the quotient is out of range,
// and a singular matrix skips division altogether.
// busy drops in the cycle the last result is shown. Synchronous reset
// clears the load count and the sequencer; stored elements are undefined.
`timescale 1ns / 1ps

module matrix4_inverse_unit
  import mi4_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_element_in,
  output logic               out_valid,
  output logic signed [31:0] out_element_out,
  output logic               out_singular,
  output logic               out_last_element
);

  localparam int NUMW = 100 + 2 * FRAC_BITS;
  localparam int DW   = (NUMW > 170) ? NUMW : 170;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LDX   = 4'd1;
  localparam logic [3:0] S_LDY   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_FLUSH = 4'd4;
  localparam logic [3:0] S_WB    = 4'd5;
  localparam logic [3:0] S_PREP  = 4'd6;
  localparam logic [3:0] S_DSET  = 4'd7;
  localparam logic [3:0] S_DCHK  = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [31:0]            mat_r [16];
  logic [95:0]            s2_r  [12];
  logic [YW-1:0]          cof_r [16];

  logic [3:0]             state_r, state_nxt;
  logic [3:0]             load_cnt_r, load_cnt_nxt;
  logic [4:0]             grp_r, grp_nxt;
  logic [1:0]             trm_r, trm_nxt;
  logic [1:0]             lmb_r, lmb_nxt;
  logic [3:0]             k_r, k_nxt;
  logic [4:0]             bit_r, bit_nxt;
  logic                   pv_r;
  logic                   out_valid_r, out_valid_nxt;

  logic [31:0]            xbuf_r;
  logic [YW-1:0]          ybuf_r;
  logic signed [65:0]     prod_r;
  logic [1:0]             sh_r;
  logic [AW-1:0]          acc_r;
  logic [DETW-1:0]        det_r;
  logic [DW-1:0]          dabs2_r, rem_r, dsh_r;
  logic [31:0]            q_r;
  logic                   neg_r, over_r, sing_r;
  logic [31:0]            out_elem_r;
  logic                   out_sing_r, out_last_r;

  term_t                  ti;
  logic [3:0]             mat_ra, cof_ra;
  logic [31:0]            mat_rd;
  logic [YW-1:0]          cof_rd, ysel;
  logic [31:0]            ylimb;
  logic signed [32:0]     x33, xs, y33;
  logic [AW-1:0]          pext;
  logic [DETW-1:0]        dabs;
  logic [YW-1:0]          nabs;
  logic [DW-1:0]          num_sh;
  logic                   ge;
  logic [31:0]            res;

  assign ti     = term_info(grp_r, trm_r);
  assign mat_ra = (state_r == S_LDY) ? ti.y_idx : ti.x_idx;
  assign mat_rd = mat_r[mat_ra];
  assign cof_ra = (state_r == S_DSET) ? {k_r[1:0], k_r[3:2]} : ti.y_idx;
  assign cof_rd = cof_r[cof_ra];

  always_comb begin
    case (ti.ysrc)
      YS_ELEM: ysel = {{(YW - 32){mat_rd[31]}}, mat_rd};
      YS_S2:   ysel = {{(YW - 96){s2_r[ti.y_idx][95]}}, s2_r[ti.y_idx]};
      default: ysel = cof_rd;
    endcase
  end

  assign ylimb = ybuf_r[{lmb_r, 5'b0} +: 32];
  assign y33   = $signed({(lmb_r == ti.nlimb_m1) & ylimb[31], ylimb});
  assign x33   = $signed({xbuf_r[31], xbuf_r});
  assign xs    = ti.neg ? -x33 : x33;
  assign pext  = {{(AW - 66){prod_r[65]}}, prod_r};

  assign dabs   = det_r[DETW-1] ? -det_r : det_r;
  assign nabs   = cof_rd[YW-1] ? -cof_rd : cof_rd;
  assign num_sh = (DW'(nabs) << (2 * FRAC_BITS + 1)) + (dabs2_r >> 1);
  assign ge     = (rem_r >= dsh_r);

  always_comb begin
    if (sing_r) begin
      res = '0;
    end else if (neg_r) begin
      res = (over_r || q_r > 32'h8000_0000) ? 32'h8000_0000 : -q_r;
    end else begin
      res = (over_r || q_r > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    grp_nxt       = grp_r;
    trm_nxt       = trm_r;
    lmb_nxt       = lmb_r;
    k_nxt         = k_r;
    bit_nxt       = bit_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          load_cnt_nxt = 4'(load_cnt_r + 4'd1);
          if (load_cnt_r == 4'd15) begin
            state_nxt = S_LDX;
            grp_nxt   = '0;
            trm_nxt   = '0;
            lmb_nxt   = '0;
          end
        end
      end
      S_LDX: state_nxt = S_LDY;
      S_LDY: state_nxt = S_MUL;
      S_MUL: begin
        if (lmb_r == ti.nlimb_m1) begin
          lmb_nxt = '0;
          if (ti.last) begin
            state_nxt = S_FLUSH;
          end else begin
            trm_nxt   = 2'(trm_r + 2'd1);
            state_nxt = S_LDX;
          end
        end else begin
          lmb_nxt = 2'(lmb_r + 2'd1);
        end
      end
      S_FLUSH: state_nxt = S_WB;
      S_WB: begin
        trm_nxt = '0;
        if (grp_r == GRP_DET) begin
          state_nxt = S_PREP;
        end else begin
          grp_nxt   = 5'(grp_r + 5'd1);
          state_nxt = S_LDX;
        end
      end
      S_PREP: begin
        k_nxt     = '0;
        state_nxt = (det_r == '0) ? S_EMIT : S_DSET;
      end
      S_DSET: state_nxt = S_DCHK;
      S_DCHK: begin
        bit_nxt   = 5'd31;
        state_nxt = (rem_r >= (dabs2_r << 32)) ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        bit_nxt = 5'(bit_r - 5'd1);
        if (bit_r == 5'd0) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid_nxt = 1'b1;
        k_nxt         = 4'(k_r + 4'd1);
        if (k_r == 4'd15) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = sing_r ? S_EMIT : S_DSET;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_cnt_r  <= '0;
      grp_r       <= '0;
      trm_r       <= '0;
      lmb_r       <= '0;
      k_r         <= '0;
      bit_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      grp_r       <= grp_nxt;
      trm_r       <= trm_nxt;
      lmb_r       <= lmb_nxt;
      k_r         <= k_nxt;
      bit_r       <= bit_nxt;
      pv_r        <= (state_r == S_MUL);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      mat_r[load_cnt_r] <= in_element_in;
      acc_r             <= '0;
    end else if (state_r == S_WB) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + (pext << {sh_r, 5'b0});
    end
    if (state_r == S_LDX) xbuf_r <= mat_rd;
    if (state_r == S_LDY) ybuf_r <= ysel;
    if (state_r == S_MUL) begin
      prod_r <= xs * y33;
      sh_r   <= lmb_r;
    end
    if (state_r == S_WB) begin
      if (grp_r < GRP_COF) begin
        s2_r[grp_r[3:0]] <= acc_r[95:0];
      end else if (grp_r < GRP_DET) begin
        cof_r[4'(grp_r - GRP_COF)] <= acc_r[YW-1:0];
      end else begin
        det_r <= acc_r[DETW-1:0];
      end
    end
    if (state_r == S_PREP) begin
      dabs2_r <= DW'(dabs) << 1;
      sing_r  <= (det_r == '0);
    end
    if (state_r == S_DSET) begin
      rem_r <= num_sh;
      neg_r <= cof_rd[YW-1] ^ det_r[DETW-1];
    end
    if (state_r == S_DCHK) begin
      over_r <= (rem_r >= (dabs2_r << 32));
      dsh_r  <= dabs2_r << 31;
      q_r    <= '0;
    end
    if (state_r == S_DIV) begin
      if (ge) rem_r <= rem_r - dsh_r;
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[30:0], ge};
    end
    if (state_r == S_EMIT) begin
      out_elem_r <= res;
      out_sing_r <= sing_r;
      out_last_r <= (k_r == 4'd15);
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_element_out  = out_elem_r;
  assign out_singular     = out_sing_r;
  assign out_last_element = out_last_r;

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_element |-> !busy)
    else $error("last result shown while still busy");

  a_pv_mul: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> $past(state_r == S_MUL))
    else $error("product accumulated without a multiply");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && load_cnt_r == 4'd15 |=> busy)
    else $error("sixteenth word did not start the compute");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_element_out == '0)
    else $error("singular result is nonzero");

endmodule
